@@ rtl/button_press_classifier_macros.svh @@
// Assertion macros shared by the button press classifier checkers.
// No dependencies; include by bare file name.
`ifndef BUTTON_PRESS_CLASSIFIER_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BPC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("button_press_classifier: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BPC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("button_press_classifier: next-cycle check failed");

`endif

@@ rtl/bpc_pkg.sv @@
// Shared types and constants of the button press classifier.
// No dependencies.
package bpc_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned EVENT_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME = 2'd2;

  localparam logic [TIME_W-1:0] COOLOFF_MS = 32'd100;
  localparam logic [CFG_DATA_W-1:0] HOLD_TIME_RESET = 16'd1000;

  localparam logic MODE_MOMENTARY = 1'b0;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE = 3'd0,
    EV_PRESSED = 3'd1,
    EV_SHORT = 3'd2,
    EV_LONG = 3'd3,
    EV_RELEASED = 3'd4
  } event_t;

  typedef struct packed {
    logic button_mode;
    logic active_low;
    logic [CFG_DATA_W-1:0] hold_time_ms;
  } cfg_t;

endpackage

@@ rtl/button_press_classifier.sv @@
// Button press classifier: one poll item (pin level, millisecond time) in, one event
// code out per poll. A poll is registered on entry, classified against the button state
// and written to the result register when that register is not stalled, so an item is
// taken every clock cycle while input stall is low, and one more can be taken while a
// result waits. Input stall rises only when the input and result registers are both full
// and the result is stalled. Configuration is written through cfg_we/cfg_index/cfg_data
// by the user only while no poll is in flight; the block does not enforce this.
module button_press_classifier (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic pin_valid,
  output logic pin_stall,
  input  logic pin_level,
  input  logic [bpc_pkg::TIME_W-1:0] now_ms,
  output logic event_valid,
  input  logic event_stall,
  output logic [bpc_pkg::EVENT_W-1:0] event_res
);

  bpc_pkg::cfg_t cfg;
  bpc_pkg::event_t ev;

  logic s1_valid;
  logic s1_pin;
  logic [bpc_pkg::TIME_W-1:0] s1_now;
  logic advance;
  logic pin_take;

  assign advance = s1_valid && !(event_valid && event_stall);
  assign pin_stall = s1_valid && !advance;
  assign pin_take = pin_valid && !pin_stall;

  bpc_cfg u_cfg (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cfg(cfg)
  );

  bpc_core u_core (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .step(advance),
    .pin_level(s1_pin),
    .now_ms(s1_now),
    .ev(ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pin_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pin_take) begin
      s1_pin <= pin_level;
      s1_now <= now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (advance) begin
      event_valid <= 1'b1;
    end else if (!event_stall) begin
      event_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      event_res <= ev;
    end
  end

endmodule

@@ rtl/bpc_cfg.sv @@
// Configuration register file of the button press classifier.
// Depends on bpc_pkg.
module bpc_cfg (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data,
  output bpc_pkg::cfg_t cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.button_mode <= bpc_pkg::MODE_MOMENTARY;
      cfg.active_low <= 1'b1;
      cfg.hold_time_ms <= bpc_pkg::HOLD_TIME_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bpc_pkg::CFG_BUTTON_MODE: cfg.button_mode <= cfg_data[0];
        bpc_pkg::CFG_ACTIVE_LOW: cfg.active_low <= cfg_data[0];
        bpc_pkg::CFG_HOLD_TIME: cfg.hold_time_ms <= cfg_data;
        default: ; // drop writes to unknown indexes
      endcase
    end
  end

endmodule

@@ rtl/bpc_core.sv @@
// Press classification logic and button state of the classifier.
// Depends on bpc_pkg.
module bpc_core (
  input  logic clk,
  input  logic rst,
  input  bpc_pkg::cfg_t cfg,
  input  logic step,
  input  logic pin_level,
  input  logic [bpc_pkg::TIME_W-1:0] now_ms,
  output bpc_pkg::event_t ev
);

  logic held_flag, held_flag_next;
  logic long_done, long_done_next;
  logic cooling, cooling_next;
  logic [bpc_pkg::TIME_W-1:0] long_deadline, long_deadline_next;
  logic [bpc_pkg::TIME_W-1:0] cooloff_end, cooloff_end_next;
  logic pressed;

  assign pressed = cfg.active_low ? ~pin_level : pin_level;

  always_comb begin
    held_flag_next = held_flag;
    long_done_next = long_done;
    cooling_next = cooling;
    long_deadline_next = long_deadline;
    cooloff_end_next = cooloff_end;
    ev = bpc_pkg::EV_NONE;
    if (cfg.button_mode == bpc_pkg::MODE_MOMENTARY) begin
      // Deadlines compare as plain unsigned values, no wrap handling.
      if (!(cooling && now_ms < cooloff_end)) begin
        cooling_next = 1'b0;
        priority if (pressed && !long_done && held_flag && now_ms >= long_deadline) begin
          long_done_next = 1'b1;
          held_flag_next = 1'b0;
          ev = bpc_pkg::EV_LONG;
        end else if (!pressed && held_flag) begin
          held_flag_next = 1'b0;
          ev = bpc_pkg::EV_SHORT;
        end else if (pressed && !long_done) begin
          if (!held_flag) begin
            long_deadline_next = now_ms + {16'd0, cfg.hold_time_ms};
          end
          held_flag_next = 1'b1;
        end else if (!pressed) begin
          ev = long_done ? bpc_pkg::EV_RELEASED : bpc_pkg::EV_NONE;
          cooling_next = long_done;
          long_done_next = 1'b0;
          cooloff_end_next = now_ms + bpc_pkg::COOLOFF_MS;
        end else begin
          ev = bpc_pkg::EV_NONE;
        end
      end
    end else begin
      if (!held_flag && pressed) begin
        held_flag_next = 1'b1;
        ev = bpc_pkg::EV_PRESSED;
      end else if (!pressed) begin
        held_flag_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_flag <= 1'b0;
      long_done <= 1'b0;
      cooling <= 1'b0;
      long_deadline <= '0;
      cooloff_end <= '0;
    end else if (step) begin
      held_flag <= held_flag_next;
      long_done <= long_done_next;
      cooling <= cooling_next;
      long_deadline <= long_deadline_next;
      cooloff_end <= cooloff_end_next;
    end
  end

endmodule

@@ rtl/bpc_checker.sv @@
// Port-level checks of the button press classifier, bound to the top level.
// Depends on bpc_pkg and button_press_classifier_macros.svh.
`include "button_press_classifier_macros.svh"

module bpc_checker (
  input logic clk,
  input logic rst,
  input logic pin_stall,
  input logic event_valid,
  input logic event_stall,
  input logic [bpc_pkg::EVENT_W-1:0] event_res
);

  // A stalled result stays put.
  `BPC_ASSERT_NXT(a_res_hold, clk, rst, event_valid && event_stall, event_valid && $stable(event_res))
  // Input backpressure comes only from a stalled, full result register.
  `BPC_ASSERT_IMP(a_stall_cause, clk, rst, pin_stall, event_valid && event_stall)
  // Event codes stay within the defined set.
  `BPC_ASSERT_IMP(a_code_range, clk, rst, event_valid, event_res <= bpc_pkg::EV_RELEASED)

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (.*);

@@ tb/button_press_classifier_test.sv @@
// Self-checking testbench for button_press_classifier: directed polls, then random press
// sequences under several register settings, with sender gaps and receiver stalls.
// Depends on bpc_pkg and the button_press_classifier RTL.
`timescale 1ns / 100ps

module button_press_classifier_test;

  localparam logic MODE_LATCHING = 1'b1;
  localparam logic [bpc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned PHASE_ITEMS = 215;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_BURSTY} stall_mode_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data;
  logic pin_valid;
  logic pin_stall;
  logic pin_level;
  logic [bpc_pkg::TIME_W-1:0] now_ms;
  logic event_valid;
  logic event_stall = 1'b0;
  logic [bpc_pkg::EVENT_W-1:0] event_res;

  button_press_classifier dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pin_valid(pin_valid),
    .pin_stall(pin_stall),
    .pin_level(pin_level),
    .now_ms(now_ms),
    .event_valid(event_valid),
    .event_stall(event_stall),
    .event_res(event_res)
  );

  // Classifier copy: registers and button state
  logic cfg_mode = bpc_pkg::MODE_MOMENTARY;
  logic cfg_active_low = 1'b1;
  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_hold = bpc_pkg::HOLD_TIME_RESET;
  logic btn_held = 1'b0;
  logic btn_long_done = 1'b0;
  logic btn_cooling = 1'b0;
  logic [bpc_pkg::TIME_W-1:0] btn_long_deadline = '0;
  logic [bpc_pkg::TIME_W-1:0] btn_cooloff_end = '0;

  bpc_pkg::event_t expected_events[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // Pacing of both sides
  logic gaps_on = 1'b0;
  int unsigned max_gap = 6;
  int unsigned burst_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  logic holdoff_req = 1'b0;
  int unsigned holdoff_len = 0;
  int unsigned holdoff_left = 0;
  int unsigned stall_run = 0;
  logic stall_hi = 1'b0;

  // Random poll generator state
  logic [bpc_pkg::TIME_W-1:0] gen_time = '0;
  logic gen_pressed = 1'b0;
  int unsigned gen_run = 0;
  int unsigned gen_step_max = 40;
  int unsigned gen_long_step = 400;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic bpc_pkg::event_t classify_poll(input logic pin,
                                                    input logic [bpc_pkg::TIME_W-1:0] t);
    logic pressed;
    bpc_pkg::event_t ev;
    pressed = cfg_active_low ? (pin == 1'b0) : (pin == 1'b1);
    ev = bpc_pkg::EV_NONE;
    if (cfg_mode == MODE_LATCHING) begin
      if (!btn_held && pressed) begin
        btn_held = 1'b1;
        ev = bpc_pkg::EV_PRESSED;
      end else if (!pressed) begin
        btn_held = 1'b0;
      end
      return ev;
    end
    // Cool-off after a long press masks everything; plain unsigned compares
    if (btn_cooling && t < btn_cooloff_end) return bpc_pkg::EV_NONE;
    btn_cooling = 1'b0;
    if (pressed && !btn_long_done && btn_held && t >= btn_long_deadline) begin
      btn_long_done = 1'b1;
      btn_held = 1'b0;
      ev = bpc_pkg::EV_LONG;
    end else if (!pressed && btn_held) begin
      btn_held = 1'b0;
      ev = bpc_pkg::EV_SHORT;
    end else if (pressed && !btn_long_done) begin
      if (!btn_held) btn_long_deadline = t + 32'(cfg_hold);
      btn_held = 1'b1;
    end else if (!pressed) begin
      ev = btn_long_done ? bpc_pkg::EV_RELEASED : bpc_pkg::EV_NONE;
      btn_cooling = btn_long_done;
      btn_long_done = 1'b0;
      btn_cooloff_end = t + bpc_pkg::COOLOFF_MS;
    end
    return ev;
  endfunction

  always @(posedge clk) begin : check_events
    bpc_pkg::event_t want;
    if (!rst && event_valid && !event_stall) begin
      if (expected_events.size() == 0) begin
        $error("event_res: no item expected, actual %0d", event_res);
        mismatches++;
      end else begin
        want = expected_events.pop_front();
        if (event_res !== want) begin
          $error("event_res: expected %0d, actual %0d", want, event_res);
          mismatches++;
        end
      end
    end
  end

  // Receiver stall pattern; a long hold-off overrides it
  always @(negedge clk) begin
    if (holdoff_req) begin
      holdoff_left = holdoff_len;
      holdoff_req = 1'b0;
    end
    if (holdoff_left > 0) begin
      event_stall = 1'b1;
      holdoff_left--;
    end else begin
      case (stall_mode)
        STALL_RANDOM: event_stall = ($urandom_range(0, 2) == 0);
        STALL_BURSTY: begin
          if (stall_run == 0) begin
            stall_hi = ~stall_hi;
            stall_run = stall_hi ? $urandom_range(1, 12) : $urandom_range(1, 20);
          end else begin
            stall_run--;
          end
          event_stall = stall_hi;
        end
        default: event_stall = 1'b0;
      endcase
    end
  end

  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      pin_valid = 1'b0;
    end
  endtask

  task automatic send_poll(input logic pin, input logic [bpc_pkg::TIME_W-1:0] t);
    @(negedge clk);
    pin_valid = 1'b1;
    pin_level = pin;
    now_ms = t;
    do @(posedge clk); while (pin_stall);
    expected_events.push_back(classify_poll(pin, t));
    if (gaps_on) begin
      if (burst_left == 0) begin
        idle_cycles($urandom_range(1, max_gap));
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_drain();
    @(negedge clk);
    pin_valid = 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bpc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bpc_pkg::CFG_DATA_W-1:0] data);
    wait_drain();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    case (idx)
      bpc_pkg::CFG_BUTTON_MODE: cfg_mode = data[0];
      bpc_pkg::CFG_ACTIVE_LOW: cfg_active_low = data[0];
      bpc_pkg::CFG_HOLD_TIME: cfg_hold = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic next_poll(output logic pin, output logic [bpc_pkg::TIME_W-1:0] t);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (gen_run == 0) begin
      gen_pressed = ~gen_pressed;
      gen_run = $urandom_range(1, 10);
    end else begin
      gen_run--;
    end
    if (pick < 10) gen_time += $urandom_range(0, gen_long_step);
    else gen_time += $urandom_range(0, gen_step_max);
    pin = cfg_active_low ? ~gen_pressed : gen_pressed;
    t = gen_time;
    // Noise: stray pin, time going back, jumps anywhere and near the wrap
    if (pick >= 90 && pick < 95) begin
      pin = 1'($urandom_range(0, 1));
    end else if (pick == 95 || pick == 96) begin
      t = gen_time - $urandom_range(0, 500);
    end else if (pick == 97) begin
      gen_time = $urandom();
      t = gen_time;
    end else if (pick == 98) begin
      gen_time = 32'hFFFF_FF00 + $urandom_range(0, 255);
      t = gen_time;
    end
  endtask

  task automatic test_momentary_flow();
    // Reset settings: momentary, active low, 1000 ms hold
    gaps_on = 1'b1;
    stall_mode = STALL_RANDOM;
    send_poll(1'b1, 32'd0);
    send_poll(1'b0, 32'd5);
    send_poll(1'b1, 32'd300);
    send_poll(1'b0, 32'd400);
    send_poll(1'b0, 32'd1400);
    send_poll(1'b0, 32'd1500);
    send_poll(1'b1, 32'd1600);
    send_poll(1'b0, 32'd1650);
    send_poll(1'b0, 32'd1700);
    send_poll(1'b1, 32'd1750);
  endtask

  task automatic test_time_wrap();
    // Deadline and cool-off end both wrap past zero and count as reached
    send_poll(1'b0, 32'hFFFF_FF00);
    send_poll(1'b0, 32'hFFFF_FFFF);
    send_poll(1'b1, 32'hFFFF_FFC0);
    send_poll(1'b0, 32'hFFFF_FFF0);
  endtask

  task automatic test_register_bits();
    write_reg(CFG_UNUSED, 16'hFFFF);
    write_reg(bpc_pkg::CFG_BUTTON_MODE, {15'h7FFF, bpc_pkg::MODE_MOMENTARY});
    write_reg(bpc_pkg::CFG_ACTIVE_LOW, 16'hFFFE);
    write_reg(bpc_pkg::CFG_HOLD_TIME, 16'h0000);
    send_poll(1'b1, 32'd10);
    send_poll(1'b1, 32'd1000);
    send_poll(1'b0, 32'd1010);
    write_reg(bpc_pkg::CFG_HOLD_TIME, 16'hFFFF);
    send_poll(1'b1, 32'd1200);
    send_poll(1'b1, 32'd66734);
    send_poll(1'b0, 32'd66740);
  endtask

  task automatic test_latching_and_mode_change();
    write_reg(bpc_pkg::CFG_BUTTON_MODE, {15'h0000, MODE_LATCHING});
    send_poll(1'b1, 32'd67000);
    send_poll(1'b1, 32'd67010);
    send_poll(1'b0, 32'd67020);
    send_poll(1'b1, 32'd67030);
    // Latched state carries over into momentary mode
    write_reg(bpc_pkg::CFG_BUTTON_MODE, {15'h0000, bpc_pkg::MODE_MOMENTARY});
    send_poll(1'b1, 32'd70000);
    send_poll(1'b0, 32'd70010);
  endtask

  task automatic test_random_phases();
    logic pin;
    logic [bpc_pkg::TIME_W-1:0] t;
    logic mode;
    logic polarity;
    logic [bpc_pkg::CFG_DATA_W-1:0] hold;
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin
          mode = bpc_pkg::MODE_MOMENTARY;
          polarity = 1'b1;
          hold = bpc_pkg::HOLD_TIME_RESET;
        end
        1: begin
          mode = bpc_pkg::MODE_MOMENTARY;
          polarity = 1'b0;
          hold = 16'h0000;
        end
        2: begin
          mode = bpc_pkg::MODE_MOMENTARY;
          polarity = 1'b1;
          hold = 16'hFFFF;
        end
        3: begin
          mode = bpc_pkg::MODE_MOMENTARY;
          polarity = 1'b0;
          hold = 16'($urandom_range(1, 300));
        end
        4: begin
          mode = MODE_LATCHING;
          polarity = 1'b1;
          hold = 16'($urandom_range(0, 65535));
        end
        5: begin
          mode = MODE_LATCHING;
          polarity = 1'b0;
          hold = 16'($urandom_range(0, 500));
        end
        default: begin
          mode = bpc_pkg::MODE_MOMENTARY;
          polarity = 1'b1;
          hold = 16'($urandom_range(0, 65535));
        end
      endcase
      write_reg(bpc_pkg::CFG_BUTTON_MODE, {15'h0000, mode});
      write_reg(bpc_pkg::CFG_ACTIVE_LOW, {15'h0000, polarity});
      write_reg(bpc_pkg::CFG_HOLD_TIME, hold);
      gen_step_max = hold / 3 + 40;
      gen_long_step = hold + hold / 2 + 200;
      // Mix of pacing: some phases run with no idling at all
      gaps_on = (phase % 3 != 2);
      case (phase % 3)
        0: stall_mode = STALL_RANDOM;
        1: stall_mode = STALL_BURSTY;
        default: stall_mode = STALL_NONE;
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        next_poll(pin, t);
        send_poll(pin, t);
      end
    end
  endtask

  task automatic test_backpressure();
    logic pin;
    logic [bpc_pkg::TIME_W-1:0] t;
    write_reg(bpc_pkg::CFG_BUTTON_MODE, {15'h0000, bpc_pkg::MODE_MOMENTARY});
    write_reg(bpc_pkg::CFG_HOLD_TIME, 16'd200);
    gen_step_max = 80;
    gen_long_step = 500;
    gaps_on = 1'b0;
    stall_mode = STALL_NONE;
    // Hold off the receiver while items keep coming, so the input stalls
    holdoff_len = 300;
    holdoff_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      next_poll(pin, t);
      send_poll(pin, t);
    end
    wait_drain();
    gaps_on = 1'b1;
    stall_mode = STALL_BURSTY;
    for (int i = 0; i < 20; i++) begin
      next_poll(pin, t);
      send_poll(pin, t);
    end
  endtask

  initial begin : run_tests
    int unsigned waited;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pin_valid = 1'b0;
    pin_level = 1'b0;
    now_ms = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_momentary_flow();
    test_time_wrap();
    test_register_bits();
    test_latching_and_mode_change();
    test_random_phases();
    test_backpressure();

    @(negedge clk);
    pin_valid = 1'b0;
    stall_mode = STALL_NONE;
    waited = 0;
    while (expected_events.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
